// ===== rtl/core/bsd_pkg.sv =====
// shared types and constants of the bitmap stream decoder
package bsd_pkg;

  localparam int unsigned MAX_WIDTH   = 4096;
  localparam int unsigned MAX_HEIGHT  = 4096;
  localparam int unsigned PAL_ENTRIES = 256;
  localparam int unsigned PAL_AW      = $clog2(PAL_ENTRIES);
  localparam int unsigned HDR_LEN     = 54;

  typedef enum logic [1:0] {
    KIND_PIXEL  = 2'd0,
    KIND_FORMAT = 2'd1,
    KIND_SIZE   = 2'd2,
    KIND_OFFSET = 2'd3
  } kind_e;

  typedef struct packed {
    logic              en;
    logic [PAL_AW-1:0] addr;
    logic [23:0]       data;
  } pal_wr_t;

  typedef struct packed {
    logic              emit;
    kind_e             kind;
    logic [11:0]       column;
    logic [11:0]       row;
    logic [7:0]        alpha;
    logic [7:0]        red;
    logic [7:0]        green;
    logic [7:0]        blue;
    logic              final_pixel;
    logic              lookup;
    logic              hit;
    logic [PAL_AW-1:0] idx;
  } px_res_t;

endpackage

// ===== rtl/core/bsd_palette.sv =====
// palette memory, one write port and one registered read port
module bsd_palette (
  input  logic                          clk_i,
  input  bsd_pkg::pal_wr_t              wr_i,
  input  logic                          rd_en_i,
  input  logic [bsd_pkg::PAL_AW-1:0]    rd_addr_i,
  output logic [23:0]                   rd_data_o
);

  logic [23:0] mem_q [bsd_pkg::PAL_ENTRIES];
  logic [23:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.addr] <= wr_i.data;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== rtl/core/bsd_parser.sv =====
// header, palette and pixel row parser, one byte per transfer
module bsd_parser #(
  parameter int unsigned MaxWidth  = bsd_pkg::MAX_WIDTH,
  parameter int unsigned MaxHeight = bsd_pkg::MAX_HEIGHT
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             accept_i,
  input  logic [7:0]       data_byte_i,
  input  logic             file_start_i,
  output bsd_pkg::pal_wr_t pal_wr_o,
  output bsd_pkg::px_res_t res_o
);

  localparam int unsigned WBits = $clog2(MaxWidth + 1);
  localparam int unsigned HBits = $clog2(MaxHeight + 1);
  localparam int unsigned RBits = $clog2(4 * MaxWidth + 1);
  localparam int unsigned PAW   = bsd_pkg::PAL_AW;

  localparam logic [2:0] PH_HEADER  = 3'd0;
  localparam logic [2:0] PH_PALETTE = 3'd1;
  localparam logic [2:0] PH_GAP     = 3'd2;
  localparam logic [2:0] PH_PIXELS  = 3'd3;
  localparam logic [2:0] PH_DONE    = 3'd4;

  localparam logic [5:0] POS_OFFSET  = 6'd13;
  localparam logic [5:0] POS_WIDTH   = 6'd21;
  localparam logic [5:0] POS_HEIGHT  = 6'd25;
  localparam logic [5:0] POS_BPP     = 6'd29;
  localparam logic [5:0] POS_COMPR   = 6'd33;
  localparam logic [5:0] POS_COLOURS = 6'd49;
  localparam logic [5:0] POS_LAST    = 6'd53;

  localparam logic [2:0] BYTES_NONE = 3'd0;
  localparam logic [2:0] BYTES_8    = 3'd1;
  localparam logic [2:0] BYTES_24   = 3'd3;
  localparam logic [2:0] BYTES_32   = 3'd4;

  logic [31:0]      pos_q, pos_d, pos_c;
  logic [2:0]       phase_q, phase_d, phase_c, phase_mid;
  logic [31:0]      fa_q, fa_d, fa_new;
  logic [WBits-1:0] w_q, w_d;
  logic [HBits-1:0] h_q, h_d;
  logic             top_q, top_d;
  logic [2:0]       bpp_q, bpp_d;
  logic [34:0]      pal_end_q, pal_end_d;
  logic [8:0]       cnt_q, cnt_d;
  logic [31:0]      offset_q, offset_d;
  logic             bad_q, bad_d, bad_c;
  logic [31:0]      pa_q, pa_d, pa_new;
  logic [WBits-1:0] col_q, col_d;
  logic [HBits-1:0] row_q, row_d;
  logic [RBits-1:0] rbc_q, rbc_d;
  logic [1:0]       sub_q, sub_d;
  logic [RBits-1:0] row_data_q, row_data_d, row_data_c;
  logic [RBits-1:0] row_end_q, row_end_d, row_end_c;
  logic [RBits:0]   row_rnd_c;

  logic [31:0]      mag;
  logic [31:0]      pal_k;
  logic [31:0]      count_new;
  logic             pix_done;
  logic             in_data;
  logic             row_last;
  logic [HBits-1:0] dest;
  logic [31:0]      dest32;
  logic [31:0]      col32;
  bsd_pkg::kind_e   kind_err;

  assign pos_c   = file_start_i ? '0 : pos_q;
  assign phase_c = file_start_i ? PH_HEADER : phase_q;
  assign bad_c   = file_start_i ? 1'b0 : bad_q;

  assign fa_new    = {data_byte_i, fa_q[31:8]};
  assign mag       = fa_new[31] ? (32'd0 - fa_new) : fa_new;
  assign pal_k     = pos_c - 32'(bsd_pkg::HDR_LEN);
  assign count_new = (bpp_q == BYTES_8 && fa_new == '0) ? 32'(bsd_pkg::PAL_ENTRIES) : fa_new;

  assign row_data_c = RBits'(32'(w_q) * 32'(bpp_q));
  assign row_rnd_c  = {1'b0, row_data_c} + (RBits+1)'(3);
  assign row_end_c  = RBits'({row_rnd_c[RBits:2], 2'b00} - (RBits+1)'(1));

  always_comb begin
    case (sub_q)
      2'd0:    pa_new = {24'd0, data_byte_i};
      2'd1:    pa_new = {pa_q[31:16], data_byte_i, pa_q[7:0]};
      2'd2:    pa_new = {pa_q[31:24], data_byte_i, pa_q[15:0]};
      default: pa_new = {data_byte_i, pa_q[23:0]};
    endcase
  end

  assign pix_done = ({1'b0, sub_q} == (bpp_q - 3'd1));
  assign in_data  = rbc_q < row_data_q;
  assign row_last = rbc_q == row_end_q;
  assign dest     = top_q ? row_q : (h_q - HBits'(1) - row_q);
  assign dest32   = 32'(dest);
  assign col32    = 32'(col_q);

  always_comb begin
    if (bpp_q == BYTES_NONE) begin
      kind_err = bsd_pkg::KIND_FORMAT;
    end else if (bad_c) begin
      kind_err = bsd_pkg::KIND_SIZE;
    end else if ({3'b000, offset_q} < pal_end_q) begin
      kind_err = bsd_pkg::KIND_OFFSET;
    end else begin
      kind_err = bsd_pkg::KIND_PIXEL;
    end
  end

  always_comb begin
    pos_d      = pos_q;
    phase_d    = phase_q;
    phase_mid  = phase_c;
    fa_d       = fa_q;
    w_d        = w_q;
    h_d        = h_q;
    top_d      = top_q;
    bpp_d      = bpp_q;
    pal_end_d  = pal_end_q;
    cnt_d      = cnt_q;
    offset_d   = offset_q;
    bad_d      = bad_q;
    pa_d       = pa_q;
    col_d      = col_q;
    row_d      = row_q;
    rbc_d      = rbc_q;
    sub_d      = sub_q;
    row_data_d = row_data_q;
    row_end_d  = row_end_q;
    pal_wr_o   = '0;
    res_o      = '0;

    if (accept_i) begin
      bad_d = bad_c;
      pos_d = (&pos_c) ? pos_c : pos_c + 32'd1;

      case (phase_c)
        PH_HEADER: begin
          fa_d = fa_new;
          case (pos_c[5:0])
            POS_OFFSET: offset_d = fa_new;
            POS_WIDTH: begin
              if (fa_new[31] || fa_new > 32'(MaxWidth)) begin
                bad_d = 1'b1;
                w_d   = '0;
              end else begin
                w_d = fa_new[WBits-1:0];
              end
            end
            POS_HEIGHT: begin
              top_d = fa_new[31];
              if (mag > 32'(MaxHeight)) begin
                bad_d = 1'b1;
                h_d   = '0;
              end else begin
                h_d = mag[HBits-1:0];
              end
            end
            POS_BPP: begin
              case (fa_new[31:16])
                16'd8:   bpp_d = BYTES_8;
                16'd24:  bpp_d = BYTES_24;
                16'd32:  bpp_d = BYTES_32;
                default: bpp_d = BYTES_NONE;
              endcase
            end
            POS_COMPR: begin
              if (fa_new != '0) begin
                bpp_d = BYTES_NONE;
              end
            end
            POS_COLOURS: begin
              cnt_d     = (count_new[31:8] != '0) ? 9'd256 : {1'b0, count_new[7:0]};
              pal_end_d = 35'(bsd_pkg::HDR_LEN) + {1'b0, count_new, 2'b00};
            end
            POS_LAST: begin
              if (kind_err != bsd_pkg::KIND_PIXEL) begin
                phase_mid  = PH_DONE;
                res_o.emit = 1'b1;
                res_o.kind = kind_err;
              end else begin
                phase_mid = PH_PALETTE;
              end
            end
            default: ;
          endcase
        end

        PH_PALETTE: begin
          case (pal_k[1:0])
            2'd0: fa_d = {24'd0, data_byte_i};
            2'd1: fa_d = {fa_q[31:16], data_byte_i, fa_q[7:0]};
            2'd2: begin
              if (pal_k[31:PAW+2] == '0) begin
                pal_wr_o.en   = 1'b1;
                pal_wr_o.addr = pal_k[PAW+1:2];
                pal_wr_o.data = {data_byte_i, fa_q[15:0]};
              end
            end
            default: ;
          endcase
        end

        PH_PIXELS: begin
          if (in_data) begin
            pa_d = pa_new;
            if (pix_done) begin
              sub_d             = 2'd0;
              col_d             = col_q + WBits'(1);
              res_o.emit        = 1'b1;
              res_o.kind        = bsd_pkg::KIND_PIXEL;
              res_o.column      = col32[11:0];
              res_o.row         = dest32[11:0];
              res_o.final_pixel = (col_q == w_q - WBits'(1)) && (row_q == h_q - HBits'(1));
              if (bpp_q == BYTES_8) begin
                res_o.lookup = 1'b1;
                res_o.idx    = pa_new[PAW-1:0];
                res_o.hit    = {1'b0, pa_new[7:0]} < cnt_q;
              end else begin
                res_o.blue  = pa_new[7:0];
                res_o.green = pa_new[15:8];
                res_o.red   = pa_new[23:16];
                res_o.alpha = (bpp_q == BYTES_32) ? pa_new[31:24] : 8'hFF;
              end
            end else begin
              sub_d = sub_q + 2'd1;
            end
          end
          if (row_last) begin
            rbc_d = '0;
            col_d = '0;
            sub_d = 2'd0;
            row_d = row_q + HBits'(1);
            if (row_q == h_q - HBits'(1)) begin
              phase_mid = PH_DONE;
            end
          end else begin
            rbc_d = rbc_q + RBits'(1);
          end
        end

        default: ;
      endcase

      phase_d = phase_mid;
      if (phase_d == PH_PALETTE && {3'b000, pos_d} >= pal_end_q) begin
        phase_d = PH_GAP;
      end
      if (phase_d == PH_GAP && pos_d >= offset_q) begin
        phase_d    = (w_q == '0 || h_q == '0 || bpp_q == BYTES_NONE) ? PH_DONE : PH_PIXELS;
        pa_d       = '0;
        col_d      = '0;
        row_d      = '0;
        rbc_d      = '0;
        sub_d      = 2'd0;
        row_data_d = row_data_c;
        row_end_d  = row_end_c;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q      <= '0;
      phase_q    <= PH_HEADER;
      fa_q       <= '0;
      w_q        <= '0;
      h_q        <= '0;
      top_q      <= 1'b0;
      bpp_q      <= BYTES_NONE;
      pal_end_q  <= '0;
      cnt_q      <= '0;
      offset_q   <= '0;
      bad_q      <= 1'b0;
      pa_q       <= '0;
      col_q      <= '0;
      row_q      <= '0;
      rbc_q      <= '0;
      sub_q      <= 2'd0;
      row_data_q <= '0;
      row_end_q  <= '0;
    end else begin
      pos_q      <= pos_d;
      phase_q    <= phase_d;
      fa_q       <= fa_d;
      w_q        <= w_d;
      h_q        <= h_d;
      top_q      <= top_d;
      bpp_q      <= bpp_d;
      pal_end_q  <= pal_end_d;
      cnt_q      <= cnt_d;
      offset_q   <= offset_d;
      bad_q      <= bad_d;
      pa_q       <= pa_d;
      col_q      <= col_d;
      row_q      <= row_d;
      rbc_q      <= rbc_d;
      sub_q      <= sub_d;
      row_data_q <= row_data_d;
      row_end_q  <= row_end_d;
    end
  end

endmodule

// ===== rtl/core/bsd_result.sv =====
// lookup stage and output register with the stream handshake
module bsd_result (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             accept_i,
  input  bsd_pkg::px_res_t res_i,
  input  logic [23:0]      pal_rdata_i,
  input  logic             out_ready_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  output logic [1:0]       kind_o,
  output logic [11:0]      column_o,
  output logic [11:0]      row_o,
  output logic [7:0]       alpha_o,
  output logic [7:0]       red_o,
  output logic [7:0]       green_o,
  output logic [7:0]       blue_o,
  output logic             final_pixel_o
);

  bsd_pkg::px_res_t s1_q;
  logic             s1_v_q, s1_v_d;
  logic             out_v_q, out_v_d;
  logic             out_load;
  logic [7:0]       a_c, r_c, g_c, b_c;

  logic [1:0]       kind_q;
  logic [11:0]      column_q, row_q;
  logic [7:0]       alpha_q, red_q, green_q, blue_q;
  logic             final_q;

  assign out_load   = s1_v_q && (!out_v_q || out_ready_i);
  assign in_ready_o = !s1_v_q || out_load;

  always_comb begin
    s1_v_d = s1_v_q;
    if (accept_i) begin
      s1_v_d = res_i.emit;
    end else if (out_load) begin
      s1_v_d = 1'b0;
    end
    out_v_d = out_v_q;
    if (out_load) begin
      out_v_d = 1'b1;
    end else if (out_ready_i) begin
      out_v_d = 1'b0;
    end
  end

  // palette entries resolve here, from the palette read data registered together with s1_q
  always_comb begin
    if (s1_q.lookup) begin
      a_c = s1_q.hit ? 8'hFF : 8'h00;
      r_c = s1_q.hit ? pal_rdata_i[23:16] : 8'h00;
      g_c = s1_q.hit ? pal_rdata_i[15:8] : 8'h00;
      b_c = s1_q.hit ? pal_rdata_i[7:0] : 8'h00;
    end else begin
      a_c = s1_q.alpha;
      r_c = s1_q.red;
      g_c = s1_q.green;
      b_c = s1_q.blue;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      s1_v_q  <= s1_v_d;
      out_v_q <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i && res_i.emit) begin
      s1_q <= res_i;
    end
    if (out_load) begin
      kind_q   <= s1_q.kind;
      column_q <= s1_q.column;
      row_q    <= s1_q.row;
      alpha_q  <= a_c;
      red_q    <= r_c;
      green_q  <= g_c;
      blue_q   <= b_c;
      final_q  <= s1_q.final_pixel;
    end
  end

  assign out_valid_o   = out_v_q;
  assign kind_o        = kind_q;
  assign column_o      = column_q;
  assign row_o         = row_q;
  assign alpha_o       = alpha_q;
  assign red_o         = red_q;
  assign green_o       = green_q;
  assign blue_o        = blue_q;
  assign final_pixel_o = final_q;

endmodule

// ===== rtl/core/bmp_stream_decoder.sv =====
// bitmap stream decoder: one file byte in per transfer, at most one ARGB pixel or error out
// Takes one byte per cycle with no gaps of its own; a byte that ends a pixel or a bad header
// gives its result through one register stage for the palette read and one output register.
// The 256 x 24-bit palette sits in a synchronous memory that is written while the palette bytes
// stream in and read once per 8-bit pixel; entries are never cleared, so the block is ready
// right after reset. Ready drops only while both result registers are full.
module bmp_stream_decoder #(
  parameter int unsigned MaxWidth  = bsd_pkg::MAX_WIDTH,
  parameter int unsigned MaxHeight = bsd_pkg::MAX_HEIGHT
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  input  logic        file_start_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  kind_o,
  output logic [11:0] column_o,
  output logic [11:0] row_o,
  output logic [7:0]  alpha_o,
  output logic [7:0]  red_o,
  output logic [7:0]  green_o,
  output logic [7:0]  blue_o,
  output logic        final_pixel_o
);

  logic             accept;
  logic             rd_en;
  logic [23:0]      pal_rdata;
  bsd_pkg::pal_wr_t pal_wr;
  bsd_pkg::px_res_t res;

  assign accept = in_valid_i && in_ready_o;
  assign rd_en  = accept && res.emit && res.lookup;

  bsd_parser #(
    .MaxWidth  (MaxWidth),
    .MaxHeight (MaxHeight)
  ) u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .data_byte_i  (data_byte_i),
    .file_start_i (file_start_i),
    .pal_wr_o     (pal_wr),
    .res_o        (res)
  );

  bsd_palette u_palette (
    .clk_i     (clk_i),
    .wr_i      (pal_wr),
    .rd_en_i   (rd_en),
    .rd_addr_i (res.idx),
    .rd_data_o (pal_rdata)
  );

  bsd_result u_result (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .res_i         (res),
    .pal_rdata_i   (pal_rdata),
    .out_ready_i   (out_ready_i),
    .in_ready_o    (in_ready_o),
    .out_valid_o   (out_valid_o),
    .kind_o        (kind_o),
    .column_o      (column_o),
    .row_o         (row_o),
    .alpha_o       (alpha_o),
    .red_o         (red_o),
    .green_o       (green_o),
    .blue_o        (blue_o),
    .final_pixel_o (final_pixel_o)
  );

`ifndef NO_ASSERTIONS
  a_err_fields_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o != bsd_pkg::KIND_PIXEL |->
      column_o == '0 && row_o == '0 && alpha_o == '0 && red_o == '0 &&
      green_o == '0 && blue_o == '0 && !final_pixel_o)
    else $error("error result with nonzero pixel fields");

  a_pal_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pal_wr.en |-> !rd_en)
    else $error("palette write and lookup in the same transfer");

  a_stall_only_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled while output can move");
`endif

endmodule

// ===== bench/tb_top.sv =====
// testbench for bmp_stream_decoder: streams whole and cut files into a scoreboard with its own decoder
module tb_top;

  localparam int unsigned CYCLE_LIMIT  = 600000;
  localparam int unsigned RANDOM_BYTES = 120;
  localparam int unsigned HOLD_CYCLES  = 300;

  typedef enum logic [2:0] {
    PH_HEADER,
    PH_PALETTE,
    PH_GAP,
    PH_PIXELS,
    PH_DONE
  } parse_phase_e;

  typedef struct packed {
    bsd_pkg::kind_e kind;
    logic [11:0]    column;
    logic [11:0]    row;
    logic [7:0]     alpha;
    logic [7:0]     red;
    logic [7:0]     green;
    logic [7:0]     blue;
    logic           fin_px;
  } bmp_result_t;

  class bmp_scoreboard;
    bmp_result_t   pending_q[$];
    parse_phase_e  phase;
    int unsigned   pos, asm_word, width, height, bpp, ncolors, data_off;
    int unsigned   pix_word, cur_col, cur_row, row_byte;
    bit            top_down, size_bad;
    logic [23:0]   palette [bsd_pkg::PAL_ENTRIES];
    int unsigned   pixels_seen, errors_seen, fails;

    function new();
      restart();
      foreach (palette[i]) palette[i] = '0;
      pixels_seen = 0;
      errors_seen = 0;
      fails = 0;
    endfunction

    function void restart();
      pos = 0;
      phase = PH_HEADER;
      asm_word = 0;
      width = 0;
      height = 0;
      top_down = 0;
      bpp = 0;
      ncolors = 0;
      data_off = 0;
      pix_word = 0;
      cur_col = 0;
      cur_row = 0;
      row_byte = 0;
      size_bad = 0;
    endfunction

    function void note_byte(logic [7:0] b, logic fs);
      bmp_result_t     res;
      int unsigned     k, sub, dest, idx, rb, mag;
      logic [23:0]     entry;
      longint unsigned pal_end;
      if (fs) restart();
      res = '0;
      case (phase)
        PH_HEADER: begin
          asm_word = {b, asm_word[31:8]};
          case (pos)
            13: data_off = asm_word;
            21: begin
              if (asm_word[31] || asm_word > bsd_pkg::MAX_WIDTH) begin
                size_bad = 1;
                width = 0;
              end else begin
                width = asm_word;
              end
            end
            25: begin
              mag = asm_word;
              top_down = asm_word[31];
              if (top_down) mag = 0 - mag;
              if (mag > bsd_pkg::MAX_HEIGHT) begin
                size_bad = 1;
                height = 0;
              end else begin
                height = mag;
              end
            end
            29: begin
              case (asm_word[31:16])
                16'd8:   bpp = 1;
                16'd24:  bpp = 3;
                16'd32:  bpp = 4;
                default: bpp = 0;
              endcase
            end
            33: if (asm_word != 0) bpp = 0;
            49: begin
              ncolors = asm_word;
              if (bpp == 1 && ncolors == 0) ncolors = bsd_pkg::PAL_ENTRIES;
            end
            53: begin
              pal_end = 64'd54 + 64'd4 * ncolors;
              res.kind = bsd_pkg::KIND_PIXEL;
              if (bpp == 0) res.kind = bsd_pkg::KIND_FORMAT;
              else if (size_bad) res.kind = bsd_pkg::KIND_SIZE;
              else if (data_off < pal_end) res.kind = bsd_pkg::KIND_OFFSET;
              if (res.kind != bsd_pkg::KIND_PIXEL) begin
                phase = PH_DONE;
                pending_q.push_back(res);
              end else begin
                phase = PH_PALETTE;
              end
            end
            default: ;
          endcase
        end
        PH_PALETTE: begin
          k = pos - 54;
          case (k[1:0])
            2'd0: asm_word = {24'd0, b};
            2'd1: asm_word[15:8] = b;
            2'd2: begin
              asm_word[23:16] = b;
              if ((k >> 2) < bsd_pkg::PAL_ENTRIES) palette[k >> 2] = asm_word[23:0];
            end
            default: ;
          endcase
        end
        PH_PIXELS: begin
          rb = ((bpp * 8 * width + 31) / 32) * 4;
          if (row_byte < width * bpp) begin
            sub = row_byte - cur_col * bpp;
            if (sub > 3) sub = 3;
            if (sub == 0) pix_word = {24'd0, b};
            else pix_word[8*sub +: 8] = b;
            if (sub == bpp - 1) begin
              dest = top_down ? cur_row : height - 1 - cur_row;
              res.kind = bsd_pkg::KIND_PIXEL;
              if (bpp == 1) begin
                idx = pix_word[7:0];
                entry = '0;
                res.alpha = 8'd0;
                if (idx < ncolors) begin
                  entry = palette[idx];
                  res.alpha = 8'd255;
                end
                res.red = entry[23:16];
                res.green = entry[15:8];
                res.blue = entry[7:0];
              end else begin
                res.blue = pix_word[7:0];
                res.green = pix_word[15:8];
                res.red = pix_word[23:16];
                res.alpha = (bpp == 4) ? pix_word[31:24] : 8'd255;
              end
              res.column = cur_col[11:0];
              res.row = dest[11:0];
              res.fin_px = (cur_col + 1 == width) && (cur_row + 1 == height);
              pending_q.push_back(res);
              cur_col++;
            end
          end
          if (row_byte + 1 >= rb) begin
            row_byte = 0;
            cur_col = 0;
            cur_row++;
            if (cur_row >= height) phase = PH_DONE;
          end else begin
            row_byte++;
          end
        end
        default: ;
      endcase
      if (pos != 32'hFFFF_FFFF) pos++;
      if (phase == PH_PALETTE && 64'(pos) >= 64'd54 + 64'd4 * ncolors) phase = PH_GAP;
      if (phase == PH_GAP && pos >= data_off) begin
        phase = PH_PIXELS;
        pix_word = 0;
        cur_col = 0;
        cur_row = 0;
        row_byte = 0;
        if (width == 0 || height == 0 || bpp == 0) phase = PH_DONE;
      end
    endfunction

    function void field_check(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        fails++;
        if (fails <= 50) begin
          $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
        end
      end
    endfunction

    function void check_result(bmp_result_t got);
      bmp_result_t want;
      if (pending_q.size() == 0) begin
        fails++;
        if (fails <= 50) begin
          $display("%0t: unexpected result, expected none actual kind %0d column %0d row %0d",
                   $time, got.kind, got.column, got.row);
        end
        return;
      end
      want = pending_q.pop_front();
      field_check("kind", want.kind, got.kind);
      field_check("column", want.column, got.column);
      field_check("row", want.row, got.row);
      field_check("alpha", want.alpha, got.alpha);
      field_check("red", want.red, got.red);
      field_check("green", want.green, got.green);
      field_check("blue", want.blue, got.blue);
      field_check("final_pixel", want.fin_px, got.fin_px);
      if (want.kind == bsd_pkg::KIND_PIXEL) pixels_seen++;
      else errors_seen++;
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic [7:0]  data_byte_i = 8'd0;
  logic        file_start_i = 1'b0;
  logic        out_ready_i = 1'b0;
  logic        in_ready_o;
  logic        out_valid_o;
  logic [1:0]  kind_o;
  logic [11:0] column_o;
  logic [11:0] row_o;
  logic [7:0]  alpha_o;
  logic [7:0]  red_o;
  logic [7:0]  green_o;
  logic [7:0]  blue_o;
  logic        final_pixel_o;

  bmp_scoreboard sb = new();
  logic [7:0]    file_q[$];
  int unsigned   burst_left = 0;
  bit            gaps_on = 1'b1;
  logic          hold_req = 1'b0;
  logic          hold_done = 1'b0;
  int unsigned   bytes_sent = 0;
  int unsigned   files_sent = 0;
  int unsigned   cycles = 0;

  bmp_stream_decoder dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .data_byte_i   (data_byte_i),
    .file_start_i  (file_start_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .kind_o        (kind_o),
    .column_o      (column_o),
    .row_o         (row_o),
    .alpha_o       (alpha_o),
    .red_o         (red_o),
    .green_o       (green_o),
    .blue_o        (blue_o),
    .final_pixel_o (final_pixel_o)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, sb.pending_q.size());
      $display("bmp_stream_decoder verification failed");
      $finish;
    end
  end

  always @(posedge clk_i) begin : monitor
    bmp_result_t got;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) sb.note_byte(data_byte_i, file_start_i);
      if (out_valid_o && out_ready_i) begin
        got.kind = bsd_pkg::kind_e'(kind_o);
        got.column = column_o;
        got.row = row_o;
        got.alpha = alpha_o;
        got.red = red_o;
        got.green = green_o;
        got.blue = blue_o;
        got.fin_px = final_pixel_o;
        sb.check_result(got);
      end
    end
  end

  initial begin : receiver
    int unsigned mode, len, tick;
    tick = 0;
    forever begin
      mode = $urandom_range(0, 3);
      len = $urandom_range(20, 150);
      repeat (len) begin
        @(posedge clk_i);
        tick++;
        if (hold_req && !hold_done) begin
          out_ready_i <= 1'b0;
          repeat (HOLD_CYCLES) @(posedge clk_i);
          hold_done <= 1'b1;
        end
        case (mode)
          0: out_ready_i <= 1'b1;
          1: out_ready_i <= 1'($urandom_range(0, 1));
          2: out_ready_i <= (tick % 5) != 0;
          default: out_ready_i <= ($urandom_range(0, 7) == 0);
        endcase
      end
    end
  end

  task automatic push_byte(logic [7:0] b, logic fs);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      if (gaps_on) begin
        gap = $urandom_range(1, 6);
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid_i <= 1'b1;
    data_byte_i <= b;
    file_start_i <= fs;
    do @(posedge clk_i); while (!in_ready_o);
    bytes_sent++;
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (sb.pending_q.size() != 0);
  endtask

  function automatic void add_header(int unsigned off, int unsigned w, int unsigned h,
                                     int unsigned bits, int unsigned comp,
                                     int unsigned colors);
    logic [7:0] hdr [54];
    foreach (hdr[i]) hdr[i] = 8'($urandom);
    hdr[0] = 8'h42;
    hdr[1] = 8'h4d;
    for (int i = 0; i < 4; i++) begin
      hdr[10+i] = off[8*i +: 8];
      hdr[18+i] = w[8*i +: 8];
      hdr[22+i] = h[8*i +: 8];
      hdr[30+i] = comp[8*i +: 8];
      hdr[46+i] = colors[8*i +: 8];
    end
    hdr[28] = bits[7:0];
    hdr[29] = bits[15:8];
    foreach (hdr[i]) file_q.push_back(hdr[i]);
  endfunction

  function automatic void build_image(int unsigned w, int h, int unsigned bits,
                                      int unsigned colors, int unsigned gap,
                                      int unsigned tail);
    int unsigned ec, bpb, rb, hh, lim;
    ec = (bits == 8 && colors == 0) ? bsd_pkg::PAL_ENTRIES : colors;
    lim = (ec > bsd_pkg::PAL_ENTRIES) ? bsd_pkg::PAL_ENTRIES : ec;
    bpb = bits / 8;
    hh = (h < 0) ? -h : h;
    rb = ((bpb * 8 * w + 31) / 32) * 4;
    file_q.delete();
    add_header(54 + 4 * ec + gap, w, h, bits, 0, colors);
    repeat (4 * ec + gap) file_q.push_back(8'($urandom));
    for (int y = 0; y < hh; y++) begin
      for (int x = 0; x < rb; x++) begin
        if (bits == 8 && x < w && lim != 0 && !(lim < 256 && $urandom_range(0, 7) == 0)) begin
          file_q.push_back(8'($urandom_range(0, lim - 1)));
        end else if (bits == 8 && x < w && lim < 256) begin
          // index past the colour count
          file_q.push_back(8'($urandom_range(lim, 255)));
        end else begin
          file_q.push_back(8'($urandom));
        end
      end
    end
    repeat (tail) file_q.push_back(8'($urandom));
  endfunction

  task automatic send_file(int unsigned cut);
    int unsigned n;
    n = (cut == 0 || cut > file_q.size()) ? file_q.size() : cut;
    for (int i = 0; i < n; i++) push_byte(file_q[i], i == 0);
    files_sent++;
  endtask

  task automatic send_header_only(int unsigned off, int unsigned w, int unsigned h,
                                  int unsigned bits, int unsigned comp,
                                  int unsigned colors, int unsigned tail);
    file_q.delete();
    add_header(off, w, h, bits, comp, colors);
    repeat (tail) file_q.push_back(8'($urandom));
    send_file(0);
  endtask

  initial begin : stimulus
    int unsigned start_bytes, pick, w, bits, colors, h_mag;
    int          h;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed files
    build_image(3, 2, 8, 4, 3, 2);
    send_file(0);
    send_header_only(54, 2, 2, 24, 1, 0, 0);
    send_header_only(54, 2, -(bsd_pkg::MAX_HEIGHT + 1), 24, 0, 0, 0);
    send_header_only(54, 2, 2, 8, 0, 0, 0);
    wait_drained();

    // long receiver hold while the sender keeps streaming
    gaps_on = 1'b0;
    hold_req <= 1'b1;
    build_image(3, 3, 32, 0, 0, 0);
    send_file(0);
    gaps_on = 1'b1;
    wait_drained();

    start_bytes = bytes_sent;
    while (bytes_sent - start_bytes < RANDOM_BYTES) begin
      gaps_on = ($urandom_range(0, 3) != 0);
      pick = $urandom_range(0, 19);
      if (pick <= 14) begin
        case ($urandom_range(0, 2))
          0: bits = 8;
          1: bits = 24;
          default: bits = 32;
        endcase
        w = $urandom_range(1, 6);
        h_mag = $urandom_range(1, 4);
        h = $urandom_range(0, 1) ? int'(h_mag) : -int'(h_mag);
        if (bits == 8) colors = $urandom_range(1, 8);
        else colors = $urandom_range(0, 2);
        build_image(w, h, bits, colors, $urandom_range(0, 4), $urandom_range(0, 3));
        if (pick >= 13) send_file($urandom_range(1, file_q.size() - 1));
        else send_file(0);
      end else if (pick <= 16) begin
        case ($urandom_range(0, 4))
          0: bits = 8;
          1: bits = 24;
          2: bits = 32;
          3: bits = 16;
          default: bits = 1;
        endcase
        case ($urandom_range(0, 2))
          0: w = 3;
          1: w = bsd_pkg::MAX_WIDTH + 1;
          default: w = 32'hFFFF_FFFE;
        endcase
        case ($urandom_range(0, 2))
          0: h = 2;
          1: h = -2;
          default: h = bsd_pkg::MAX_HEIGHT + 1;
        endcase
        colors = $urandom_range(1, 4);
        send_header_only(54 + 4 * colors - $urandom_range(0, 1), w, h, bits,
                         ($urandom_range(0, 3) == 0), colors, $urandom_range(0, 4));
      end else if (pick <= 18) begin
        repeat ($urandom_range(5, 30)) push_byte(8'($urandom), $urandom_range(0, 7) == 0);
      end else begin
        wait_drained();
      end
    end

    wait_drained();
    repeat (20) @(posedge clk_i);
    $display("run streamed %0d files in %0d bytes with random gaps and output stalls",
             files_sent, bytes_sent);
    $display("checked %0d pixels and %0d error results, %0d mismatches",
             sb.pixels_seen, sb.errors_seen, sb.fails);
    if (sb.fails == 0 && sb.pending_q.size() == 0) begin
      $display("bmp_stream_decoder verification clean");
    end else begin
      $display("bmp_stream_decoder verification failed");
    end
    $finish;
  end

endmodule
